// ----- sv/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiply unit.
// Used by every module under sv/; no dependencies of its own.
package mvm_pkg;

  localparam int MAX_DIM   = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 64;

  // result queue depth; covers the three pipeline stages plus drain slack
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_DIMENSION = '0;
  localparam logic [DIM_W-1:0]  DIM_RESET     = DIM_W'(MAX_DIM);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_MATRIX = 1'b1
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [5:0]         vector_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         row_index;
    logic signed [31:0] row_sum;
    logic               saturated;
    logic               last_row;
  } out_item_t;

  // control from the register block
  typedef struct packed {
    logic [DIM_W-1:0] dim_active;
    logic             restart;
  } cfg_t;

  // per-element control carried down the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first_col;
    logic             last_col;
    logic [IDX_W-1:0] row;
    logic             last_row;
  } tag_t;

endpackage

// ----- sv/mvm_cfg_regs.sv -----
// APB register block: holds the dimension register and the clamped size.
// Depends on mvm_pkg.
module mvm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvm_pkg::DATA_W-1:0]   pwdata,
  output logic [mvm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output mvm_pkg::cfg_t                cfg
);

  logic [mvm_pkg::DIM_W-1:0] dimension;
  logic [mvm_pkg::DIM_W-1:0] dim_active;
  logic [mvm_pkg::DIM_W-1:0] dim_written;
  logic                      hit;
  logic                      wr_en;

  assign pready      = 1'b1;
  assign hit         = (paddr[mvm_pkg::ADDR_W-1:2] == mvm_pkg::REG_DIMENSION);
  assign wr_en       = psel && penable && pwrite && pready && hit;
  assign dim_written = pwdata[mvm_pkg::DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension  <= mvm_pkg::DIM_RESET;
      dim_active <= mvm_pkg::DIM_RESET;
    end else if (wr_en) begin
      dimension <= dim_written;
      // zero acts as one, oversize acts as the maximum
      if (dim_written == '0) begin
        dim_active <= mvm_pkg::DIM_W'(1);
      end else if (dim_written > mvm_pkg::DIM_W'(mvm_pkg::MAX_DIM)) begin
        dim_active <= mvm_pkg::DIM_W'(mvm_pkg::MAX_DIM);
      end else begin
        dim_active <= dim_written;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = mvm_pkg::DATA_W'(dimension);
    end
  end

  assign cfg.dim_active = dim_active;
  assign cfg.restart    = wr_en;

endmodule

// ----- sv/mvm_vector_mem.sv -----
// Vector element store: one write port, one registered read port.
// Depends on mvm_pkg.
module mvm_vector_mem (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [mvm_pkg::IDX_W-1:0]        wr_addr,
  input  logic signed [mvm_pkg::VAL_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [mvm_pkg::IDX_W-1:0]        rd_addr,
  output logic signed [mvm_pkg::VAL_W-1:0] rd_data
);

  logic signed [mvm_pkg::VAL_W-1:0] mem [mvm_pkg::MAX_DIM];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/mvm_mac_pipe.sv -----
// Multiply, saturating accumulate, and floor/saturate to Q16.16.
// Depends on mvm_pkg; fed by the vector store read port.
module mvm_mac_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  mvm_pkg::tag_t                    s1_tag,
  input  logic signed [mvm_pkg::VAL_W-1:0] s1_value,
  input  logic signed [mvm_pkg::VAL_W-1:0] s1_vec,
  output logic                             push,
  output mvm_pkg::out_item_t               push_data,
  output logic [1:0]                       pending
);

  localparam logic signed [mvm_pkg::ACC_W-1:0] SUM_MAX = 64'sd2147483647;
  localparam logic signed [mvm_pkg::ACC_W-1:0] SUM_MIN = -64'sd2147483648;
  localparam logic signed [mvm_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [mvm_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}};

  mvm_pkg::tag_t                    s2_tag;
  logic signed [mvm_pkg::ACC_W-1:0] s2_prod;
  logic signed [mvm_pkg::ACC_W-1:0] acc;
  logic signed [mvm_pkg::ACC_W-1:0] acc_base;
  logic signed [mvm_pkg::ACC_W-1:0] acc_raw;
  logic signed [mvm_pkg::ACC_W-1:0] acc_next;
  logic                             s3_valid;
  logic signed [mvm_pkg::ACC_W-1:0] s3_sum;
  logic [mvm_pkg::IDX_W-1:0]        s3_row;
  logic                             s3_last;
  logic signed [mvm_pkg::ACC_W-1:0] shifted;

  // stage 2: exact Q32.32 product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else begin
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    s2_prod <= mvm_pkg::ACC_W'(s1_value) * mvm_pkg::ACC_W'(s1_vec);
  end

  // accumulate with clamp at the 64-bit limits
  always_comb begin
    acc_base = s2_tag.first_col ? '0 : acc;
    acc_raw  = acc_base + s2_prod;
    acc_next = acc_raw;
    if ((acc_base[mvm_pkg::ACC_W-1] == s2_prod[mvm_pkg::ACC_W-1]) &&
        (acc_raw[mvm_pkg::ACC_W-1] != acc_base[mvm_pkg::ACC_W-1])) begin
      acc_next = acc_base[mvm_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_tag.valid) begin
      acc <= acc_next;
    end
  end

  // stage 3: finished row sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_tag.valid && s2_tag.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_tag.valid && s2_tag.last_col) begin
      s3_sum  <= acc_next;
      s3_row  <= s2_tag.row;
      s3_last <= s2_tag.last_row;
    end
  end

  // arithmetic shift is floor division by 2^FRAC_BITS
  always_comb begin
    shifted             = s3_sum >>> mvm_pkg::FRAC_BITS;
    push_data.row_index = s3_row;
    push_data.last_row  = s3_last;
    push_data.saturated = 1'b0;
    push_data.row_sum   = shifted[mvm_pkg::VAL_W-1:0];
    if (shifted > SUM_MAX) begin
      push_data.row_sum   = SUM_MAX[mvm_pkg::VAL_W-1:0];
      push_data.saturated = 1'b1;
    end else if (shifted < SUM_MIN) begin
      push_data.row_sum   = SUM_MIN[mvm_pkg::VAL_W-1:0];
      push_data.saturated = 1'b1;
    end
  end

  assign push    = s3_valid;
  assign pending = 2'(s2_tag.valid && s2_tag.last_col) + 2'(s3_valid);

endmodule

// ----- sv/mvm_result_fifo.sv -----
// Result queue between the MAC pipeline and the output channel.
// Depends on mvm_pkg.
module mvm_result_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  mvm_pkg::out_item_t              push_data,
  input  logic                            pop,
  output logic                            valid,
  output mvm_pkg::out_item_t              head,
  output logic [mvm_pkg::RES_CNT_W-1:0]   count
);

  mvm_pkg::out_item_t               slots [mvm_pkg::RES_DEPTH];
  logic [mvm_pkg::RES_PTR_W-1:0]    wr_ptr;
  logic [mvm_pkg::RES_PTR_W-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + mvm_pkg::RES_CNT_W'(push) - mvm_pkg::RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

endmodule

// ----- sv/matrix_vector_multiply_unit.sv -----
// Matrix-vector multiply, Q16.16: one item per cycle while item_ready is high, loads and matrix elements alike.
// A row result passes the store read and issue register, the product register and the
// accumulated row-sum register (floor and saturation after it), then waits in an 8-entry queue;
// input stalls only when that queue and the results in flight would exceed its depth.
// Synchronous reset clears counters, pipeline, queue and sets dimension to 64; the
// vector store keeps its contents and must be loaded before use.
module matrix_vector_multiply_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  mvm_pkg::in_item_t            item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output mvm_pkg::out_item_t           result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvm_pkg::DATA_W-1:0]   pwdata,
  output logic [mvm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  mvm_pkg::cfg_t                    cfg;
  logic                             item_xfer;
  logic                             load_xfer;
  logic                             mat_xfer;
  logic [mvm_pkg::IDX_W-1:0]        col;
  logic [mvm_pkg::IDX_W-1:0]        row;
  logic                             col_is_last;
  logic                             row_is_last;
  mvm_pkg::tag_t                    s1_tag;
  logic signed [mvm_pkg::VAL_W-1:0] s1_value;
  logic signed [mvm_pkg::VAL_W-1:0] s1_vec;
  logic                             res_push;
  mvm_pkg::out_item_t               res_data;
  logic [1:0]                       mac_pending;
  logic [mvm_pkg::RES_CNT_W-1:0]    fifo_count;
  logic [mvm_pkg::RES_CNT_W:0]      committed;
  logic                             res_pop;

  mvm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // results queued plus results still in the pipeline
  assign committed = (mvm_pkg::RES_CNT_W+1)'(fifo_count)
                   + (mvm_pkg::RES_CNT_W+1)'(mac_pending)
                   + (mvm_pkg::RES_CNT_W+1)'(s1_tag.valid && s1_tag.last_col);
  assign item_ready = committed < (mvm_pkg::RES_CNT_W+1)'(mvm_pkg::RES_DEPTH);

  assign item_xfer = item_valid && item_ready;
  assign load_xfer = item_xfer && (item.action == mvm_pkg::ACT_LOAD) &&
                     ({1'b0, item.vector_index} < 7'(mvm_pkg::MAX_DIM));
  assign mat_xfer  = item_xfer && (item.action == mvm_pkg::ACT_MATRIX);

  assign col_is_last = ({1'b0, col} + 1'b1) == cfg.dim_active;
  assign row_is_last = ({1'b0, row} + 1'b1) == cfg.dim_active;

  mvm_vector_mem u_mem (
    .clk     (clk),
    .wr_en   (load_xfer),
    .wr_addr (item.vector_index[mvm_pkg::IDX_W-1:0]),
    .wr_data (item.value),
    .rd_en   (mat_xfer),
    .rd_addr (col),
    .rd_data (s1_vec)
  );

  // issue stage: walk the row-major position and tag each element
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      s1_tag <= '0;
    end else begin
      s1_tag.valid <= mat_xfer;
      if (mat_xfer) begin
        s1_tag.first_col <= (col == '0);
        s1_tag.last_col  <= col_is_last;
        s1_tag.row       <= row;
        s1_tag.last_row  <= row_is_last;
        if (col_is_last) begin
          col <= '0;
          row <= row_is_last ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cfg.restart) begin
        col <= '0;
        row <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mat_xfer) begin
      s1_value <= item.value;
    end
  end

  mvm_mac_pipe u_mac (
    .clk       (clk),
    .rst       (rst),
    .s1_tag    (s1_tag),
    .s1_value  (s1_value),
    .s1_vec    (s1_vec),
    .push      (res_push),
    .push_data (res_data),
    .pending   (mac_pending)
  );

  assign res_pop = result_valid && result_ready;

  mvm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (res_pop),
    .valid     (result_valid),
    .head      (result),
    .count     (fifo_count)
  );

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < cfg.dim_active)
    else $error("column position beyond dimension");

  a_row_end_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_tag.valid && s1_tag.last_col) |-> ##2 res_push)
    else $error("row end did not reach the result queue");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> ((fifo_count < mvm_pkg::RES_CNT_W'(mvm_pkg::RES_DEPTH)) || res_pop))
    else $error("result queue overflow");

endmodule

// ----- tb/sv/mvm_checker.sv -----
// Checker for the matrix-vector multiply unit: tracks vector store, row accumulator and
// counters from observed transfers and config writes, and compares each row result.
// Depends on mvm_pkg for the payload types and register constants.
module mvm_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  mvm_pkg::in_item_t          item,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  mvm_pkg::out_item_t         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvm_pkg::ADDR_W-1:0] paddr,
  input  logic [mvm_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF;
  localparam longint SUM_MIN = -64'sh8000_0000;

  logic signed [VAL_W-1:0] vec_mem [MAX_DIM];
  logic signed [ACC_W-1:0] acc;
  int unsigned             col_cnt;
  int unsigned             row_cnt;
  logic [DIM_W-1:0]        dim_reg;
  out_item_t               row_sums_due [$];
  int                      mismatch_count = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int unsigned order_of(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("ERROR %s: expected %0h, got %0h", what, want, got);
    mismatch_count++;
  endtask

  // loads fill the store, else one MAC step; a row end queues its rounded, clipped sum
  task automatic accumulate_item(in_item_t it);
    int unsigned             n;
    longint                  a;
    longint                  b;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W:0]   wide;
    logic signed [ACC_W-1:0] shifted;
    out_item_t               row_out;
    if (it.action == ACT_LOAD) begin
      vec_mem[it.vector_index] = it.value;
      return;
    end
    n = order_of(dim_reg);
    if (col_cnt >= n) col_cnt = 0;
    if (row_cnt >= n) row_cnt = 0;
    if (col_cnt == 0) acc = '0;
    a = it.value;
    b = vec_mem[col_cnt];
    prod = a * b;
    wide = acc + prod;
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      acc = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc = wide[ACC_W-1:0];
    end
    if (col_cnt + 1 < n) begin
      col_cnt++;
      return;
    end
    // arithmetic shift of a signed value rounds toward negative infinity
    shifted = acc >>> FRAC_BITS;
    row_out.saturated = 1'b0;
    if (shifted > SUM_MAX) begin
      row_out.row_sum   = 32'sh7FFF_FFFF;
      row_out.saturated = 1'b1;
    end else if (shifted < SUM_MIN) begin
      row_out.row_sum   = 32'sh8000_0000;
      row_out.saturated = 1'b1;
    end else begin
      row_out.row_sum = shifted[VAL_W-1:0];
    end
    row_out.row_index = row_cnt[5:0];
    row_out.last_row  = (row_cnt + 1 == n);
    row_sums_due.push_back(row_out);
    col_cnt = 0;
    acc     = '0;
    row_cnt = (row_cnt + 1 < n) ? row_cnt + 1 : 0;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      acc     = '0;
      col_cnt = 0;
      row_cnt = 0;
      dim_reg = DIM_RESET;
      row_sums_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_DIMENSION) begin
        dim_reg = pwdata[DIM_W-1:0];
        acc     = '0;
        col_cnt = 0;
        row_cnt = 0;
      end
      if (result_valid && result_ready) begin
        if (row_sums_due.size() == 0) begin
          report("result transfer with nothing due, row_sum", 0, result.row_sum);
        end else begin
          want = row_sums_due.pop_front();
          if (result.row_index != want.row_index)
            report("row_index", want.row_index, result.row_index);
          if (result.row_sum != want.row_sum)
            report($sformatf("row %0d row_sum", want.row_index),
                   want.row_sum, result.row_sum);
          if (result.saturated != want.saturated)
            report($sformatf("row %0d saturated", want.row_index),
                   want.saturated, result.saturated);
          if (result.last_row != want.last_row)
            report($sformatf("row %0d last_row", want.row_index),
                   want.last_row, result.last_row);
        end
      end
      if (item_valid && item_ready) accumulate_item(item);
    end
    // published a step late so the stimulus side reads them without a race
    pending <= row_sums_due.size();
    errors  <= mismatch_count;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the matrix-vector multiply testbench: clock, reset, item and config stimulus,
// result back-pressure, watchdog and verdict. Depends on mvm_pkg, mvm_checker and the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1000;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  in_item_t          item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  out_item_t         result;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int rows_pending;

  matrix_vector_multiply_unit DUT (.*);

  mvm_checker CHECK (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .errors       (mismatches),
    .pending      (rows_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side: long ready stretches, coin flips, and mostly-stalled windows
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(10, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= 1'($urandom_range(0, 1));
      default: result_ready <= (rx_left % 16) >= 12;
    endcase
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus-side mirror: active order, next column, and which store entries hold data
  int unsigned cur_n      = MAX_DIM;
  int unsigned next_col   = 0;
  bit          loaded [MAX_DIM];
  int          sent       = 0;
  int          burst_left = 0;

  function automatic int unsigned order_of(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    int unsigned             sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      case ($urandom_range(0, 5))
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2: v = 32'sh0000_0000;
        3: v = 32'shFFFF_FFFF;
        4: v = 32'sh0001_0000;
        default: v = 32'shFFFF_0000;
      endcase
    end else if (sel < 8) begin
      v = $urandom();
    end else begin
      // within +/-2.0 so sums mostly stay unclipped
      v = $urandom_range(0, 32'h3FFFF);
      v = v - 32'sh0002_0000;
    end
    return v;
  endfunction

  task automatic send(in_item_t it);
    int unsigned gap;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load(logic [5:0] idx, logic signed [VAL_W-1:0] val);
    send('{action: ACT_LOAD, vector_index: idx, value: val});
    loaded[idx] = 1'b1;
  endtask

  // a column never loaded gets a load first, so no unwritten entry is read
  task automatic matrix_elem(logic signed [VAL_W-1:0] val);
    if (!loaded[next_col]) load(6'(next_col), pick_value());
    send('{action: ACT_MATRIX, vector_index: 6'($urandom()), value: val});
    next_col = (next_col + 1 < cur_n) ? next_col + 1 : 0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(logic [DIM_W-1:0] d);
    logic [DATA_W-1:0] noise;
    noise = $urandom();
    item_valid <= 1'b0;
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_DIMENSION, 2'b00};
    pwdata  <= {noise[DATA_W-1:DIM_W], d};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_n    = order_of(d);
    next_col = 0;
  endtask

  initial begin : stimulus
    int          phase;
    int unsigned n_items;
    int unsigned r;
    logic [DIM_W-1:0] d;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // order 4: accumulator overflow both ways, floor of a tiny negative sum
    write_dim(7'd4);
    for (int i = 0; i < 4; i++) load(6'(i), 32'sh8000_0000);
    repeat (4) matrix_elem(32'sh8000_0000);
    repeat (4) matrix_elem(32'sh7FFF_FFFF);
    matrix_elem(32'sh0000_0000);
    load(6'd1, 32'shFFFF_FFFF);          // load in the middle of a row
    matrix_elem(32'sh0000_0001);
    matrix_elem(32'sh0000_0000);
    matrix_elem(32'sh0000_0000);
    load(6'd63, 32'sh7FFF_FFFF);
    repeat (4) matrix_elem(32'sh0001_0000);
    // wrap back to row 0, then restart the matrix by a write mid-row
    repeat (2) matrix_elem(32'shFFFF_0000);
    write_dim(7'd0);
    load(6'd0, 32'sh0001_0000);
    matrix_elem(32'sh7FFF_FFFF);
    matrix_elem(32'sh8000_0000);

    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase)
        0: d = 7'd64;
        1: d = 7'd127;
        2: d = 7'd1;
        3: d = 7'($urandom_range(65, 127));
        default: begin
          r = $urandom_range(0, 15);
          if (r < 10)      d = 7'($urandom_range(1, 8));
          else if (r < 14) d = 7'($urandom_range(9, 24));
          else if (r == 14) d = 7'd0;
          else             d = 7'($urandom_range(64, 127));
        end
      endcase
      write_dim(d);
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < cur_n; i++) load(6'(i), pick_value());
      end
      if (cur_n > 24) n_items = cur_n * $urandom_range(1, 2) + $urandom_range(0, 8);
      else            n_items = cur_n * $urandom_range(2, 10) + $urandom_range(0, cur_n);
      repeat (n_items) begin
        if ($urandom_range(0, 9) == 0) load(6'($urandom_range(0, 63)), pick_value());
        else                           matrix_elem(pick_value());
      end
      phase++;
    end

    item_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
